// ----- rtl/mnpv_pkg.sv -----
package mnpv_pkg;

    localparam int KEY_W  = 7;
    localparam int VEL_W  = 7;
    localparam int OP_W   = 2;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int TOP_W  = 8;

    // event opcodes
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [OP_W-1:0] OP_FORCE    = 2'd2;

    // voice status codes
    localparam logic [STAT_W-1:0] ST_OFF       = 2'd0;
    localparam logic [STAT_W-1:0] ST_ON        = 2'd1;
    localparam logic [STAT_W-1:0] ST_SUSTAINED = 2'd2;
    localparam logic [STAT_W-1:0] ST_RELEASED  = 2'd3;

    // mono mode codes
    localparam logic [MODE_W-1:0] MODE_POLY      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONO_ON   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MONO_ONCE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MONO_BOTH = 2'd3;

    localparam logic [VEL_W-1:0] FORCED_REL_VEL = 7'd64;
    localparam logic [TOP_W-1:0] EMPTY_KEY      = 8'hFF;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

    // one held-list entry, empty when valid is low
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_entry;

endpackage

// ----- rtl/mnpv_ctrl.sv -----
module mnpv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output logic            o_done,
    output mnpv_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                end
            endcase
        end
    end

    assign o_cmd.capture = i_start && !r_busy;
    assign o_cmd.execute = (r_state == S_EXEC);
    assign o_busy        = r_busy;
    assign o_done        = r_done;

endmodule

// ----- rtl/mnpv_datapath.sv -----
module mnpv_datapath #(
    parameter int HELD_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mnpv_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_wr_en,
    input  logic [mnpv_pkg::MODE_W-1:0]         i_cfg_wr_data,
    input  logic [mnpv_pkg::OP_W-1:0]           i_op,
    input  logic [mnpv_pkg::KEY_W-1:0]          i_key,
    input  logic [mnpv_pkg::VEL_W-1:0]          i_velocity,
    input  logic                                i_sustain_pedal,
    output logic [mnpv_pkg::STAT_W-1:0]         o_voice_status,
    output logic [mnpv_pkg::KEY_W-1:0]          o_sounding_key,
    output logic [mnpv_pkg::VEL_W-1:0]          o_note_velocity,
    output logic [mnpv_pkg::VEL_W-1:0]          o_release_velocity,
    output logic                                o_full_setup,
    output logic                                o_pitch_update,
    output logic                                o_restart_envelopes,
    output logic                                o_enter_release,
    output logic signed [mnpv_pkg::TOP_W-1:0]   o_top_held_key
);

    // captured event
    logic [mnpv_pkg::OP_W-1:0]   r_op;
    logic [mnpv_pkg::KEY_W-1:0]  r_key;
    logic [mnpv_pkg::VEL_W-1:0]  r_vel;
    logic                        r_pedal;

    logic [mnpv_pkg::MODE_W-1:0] r_mode;

    // voice state
    mnpv_pkg::t_entry            r_list [HELD_DEPTH];
    logic [mnpv_pkg::STAT_W-1:0] r_status;
    logic [mnpv_pkg::KEY_W-1:0]  r_vkey;
    logic [mnpv_pkg::VEL_W-1:0]  r_vvel;
    logic [mnpv_pkg::VEL_W-1:0]  r_rvel;
    logic                        r_full;
    logic                        r_pitch;
    logic                        r_restart;
    logic                        r_rel;

    mnpv_pkg::t_entry            n_list [HELD_DEPTH];
    logic [mnpv_pkg::STAT_W-1:0] n_status;
    logic [mnpv_pkg::KEY_W-1:0]  n_vkey;
    logic [mnpv_pkg::VEL_W-1:0]  n_vvel;
    logic [mnpv_pkg::VEL_W-1:0]  n_rvel;
    logic                        n_full;
    logic                        n_pitch;
    logic                        n_restart;
    logic                        n_rel;

    logic [HELD_DEPTH-1:0]       match;
    logic [HELD_DEPTH-1:0]       push_shift;
    logic [HELD_DEPTH-1:0]       rm_shift;
    mnpv_pkg::t_entry            push_list [HELD_DEPTH];
    mnpv_pkg::t_entry            rm_list   [HELD_DEPTH];
    logic                        found;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_vel   <= i_velocity;
            r_pedal <= i_sustain_pedal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mnpv_pkg::MODE_POLY;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // parallel key compare over the held list
    always_comb begin
        for (int j = 0; j < HELD_DEPTH; j++) begin
            match[j] = r_list[j].valid && (r_list[j].key == r_key);
        end
    end

    // push: entries above the first match (bottom slot excluded) move down
    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int j = 0; j < HELD_DEPTH; j++) begin
            push_shift[j] = !acc;
            if (j < HELD_DEPTH - 1) begin
                acc = acc | match[j];
            end
        end
        push_list[0].valid = 1'b1;
        push_list[0].key   = r_key;
        for (int j = 1; j < HELD_DEPTH; j++) begin
            push_list[j] = push_shift[j] ? r_list[j-1] : r_list[j];
        end
    end

    // remove: from the last match down, entries move up one place
    always_comb begin
        logic acc;
        acc   = 1'b0;
        found = |match;
        for (int j = HELD_DEPTH - 1; j >= 0; j--) begin
            rm_shift[j] = found && !acc;
            acc         = acc | match[j];
        end
        for (int j = 0; j < HELD_DEPTH - 1; j++) begin
            rm_list[j] = rm_shift[j] ? r_list[j+1] : r_list[j];
        end
        if (rm_shift[HELD_DEPTH-1]) begin
            rm_list[HELD_DEPTH-1].valid = 1'b0;
            rm_list[HELD_DEPTH-1].key   = '0;
        end else begin
            rm_list[HELD_DEPTH-1] = r_list[HELD_DEPTH-1];
        end
    end

    always_comb begin
        logic mono;
        logic playing;
        mono    = (r_mode != mnpv_pkg::MODE_POLY);
        playing = (r_status == mnpv_pkg::ST_ON) || (r_status == mnpv_pkg::ST_SUSTAINED);
        n_list    = r_list;
        n_status  = r_status;
        n_vkey    = r_vkey;
        n_vvel    = r_vvel;
        n_rvel    = r_rvel;
        n_full    = 1'b0;
        n_pitch   = 1'b0;
        n_restart = 1'b0;
        n_rel     = 1'b0;
        case (r_op)
            mnpv_pkg::OP_NOTE_ON: begin
                n_vkey = r_key;
                n_vvel = r_vel;
                if (!mono || !playing) begin
                    n_full = 1'b1;
                end else begin
                    n_pitch = 1'b1;
                    if (((r_mode == mnpv_pkg::MODE_MONO_ON) ||
                         (r_mode == mnpv_pkg::MODE_MONO_BOTH)) &&
                        (!r_list[0].valid || (r_list[0].key != r_key))) begin
                        n_restart = 1'b1;
                    end
                end
                if (mono) begin
                    n_list = push_list;
                end
                n_status = mnpv_pkg::ST_ON;
            end
            mnpv_pkg::OP_NOTE_OFF: begin
                n_rvel = r_vel;
                if (mono) begin
                    n_list = rm_list;
                end
                if (mono && rm_list[0].valid) begin
                    // fall back to the next most recent key
                    if (!r_list[0].valid || (r_list[0].key != rm_list[0].key)) begin
                        n_vkey  = rm_list[0].key;
                        n_pitch = 1'b1;
                        if ((r_mode == mnpv_pkg::MODE_MONO_BOTH) &&
                            (r_status != mnpv_pkg::ST_RELEASED)) begin
                            n_restart = 1'b1;
                        end
                    end
                end else if (r_pedal) begin
                    if (r_status != mnpv_pkg::ST_RELEASED) begin
                        n_status = mnpv_pkg::ST_SUSTAINED;
                    end
                end else begin
                    n_rel    = 1'b1;
                    n_status = mnpv_pkg::ST_RELEASED;
                end
            end
            mnpv_pkg::OP_FORCE: begin
                if (r_status == mnpv_pkg::ST_ON) begin
                    n_rvel = mnpv_pkg::FORCED_REL_VEL;
                end
                n_rel    = 1'b1;
                n_status = mnpv_pkg::ST_RELEASED;
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < HELD_DEPTH; j++) begin
                r_list[j].valid <= 1'b0;
                r_list[j].key   <= '0;
            end
            r_status  <= mnpv_pkg::ST_OFF;
            r_vkey    <= '0;
            r_vvel    <= '0;
            r_rvel    <= '0;
            r_full    <= 1'b0;
            r_pitch   <= 1'b0;
            r_restart <= 1'b0;
            r_rel     <= 1'b0;
        end else if (i_cmd.execute) begin
            r_list    <= n_list;
            r_status  <= n_status;
            r_vkey    <= n_vkey;
            r_vvel    <= n_vvel;
            r_rvel    <= n_rvel;
            r_full    <= n_full;
            r_pitch   <= n_pitch;
            r_restart <= n_restart;
            r_rel     <= n_rel;
        end
    end

    assign o_voice_status      = r_status;
    assign o_sounding_key      = r_vkey;
    assign o_note_velocity     = r_vvel;
    assign o_release_velocity  = r_rvel;
    assign o_full_setup        = r_full;
    assign o_pitch_update      = r_pitch;
    assign o_restart_envelopes = r_restart;
    assign o_enter_release     = r_rel;
    assign o_top_held_key      = r_list[0].valid ? {1'b0, r_list[0].key} : mnpv_pkg::EMPTY_KEY;

endmodule

// ----- rtl/mono_note_priority_voice_control.sv -----
// Last-note-priority controller for one synthesizer voice. Raise i_start with an
// event (note on, note off or forced release, plus key, velocity and pedal) while
// o_busy is low; the event is taken at that clock edge. The execute state then
// updates the voice state and the held-key list, and o_done pulses for exactly
// one cycle with the result on the o_ ports. The receiver cannot hold the result
// off: it must take the transfer in the o_done cycle, although the fields stay
// put until the next result. A new event is refused while the update runs and
// may be started in the strobe cycle. Each event passes through a capture into
// the event register, then an update in which the whole held list is compared in
// parallel and shifted. mono_mode is written through i_cfg_wr_en / i_cfg_wr_data
// and must only change while the block is idle.
module mono_note_priority_voice_control #(
    parameter int HELD_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // event channel
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [mnpv_pkg::OP_W-1:0]           i_op,
    input  logic [mnpv_pkg::KEY_W-1:0]          i_key,
    input  logic [mnpv_pkg::VEL_W-1:0]          i_velocity,
    input  logic                                i_sustain_pedal,
    // mode register
    input  logic                                i_cfg_wr_en,
    input  logic [mnpv_pkg::MODE_W-1:0]         i_cfg_wr_data,
    // result channel
    output logic                                o_done,
    output logic [mnpv_pkg::STAT_W-1:0]         o_voice_status,
    output logic [mnpv_pkg::KEY_W-1:0]          o_sounding_key,
    output logic [mnpv_pkg::VEL_W-1:0]          o_note_velocity,
    output logic [mnpv_pkg::VEL_W-1:0]          o_release_velocity,
    output logic                                o_full_setup,
    output logic                                o_pitch_update,
    output logic                                o_restart_envelopes,
    output logic                                o_enter_release,
    output logic signed [mnpv_pkg::TOP_W-1:0]   o_top_held_key
);

    // capture and execute commands from the sequencer
    mnpv_pkg::t_cmd cmd;

    // two-state sequencer: idle, then an update state per event
    mnpv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // event register, mode register, held list and voice state
    mnpv_datapath #(
        .HELD_DEPTH (HELD_DEPTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_op                (i_op),
        .i_key               (i_key),
        .i_velocity          (i_velocity),
        .i_sustain_pedal     (i_sustain_pedal),
        .o_voice_status      (o_voice_status),
        .o_sounding_key      (o_sounding_key),
        .o_note_velocity     (o_note_velocity),
        .o_release_velocity  (o_release_velocity),
        .o_full_setup        (o_full_setup),
        .o_pitch_update      (o_pitch_update),
        .o_restart_envelopes (o_restart_envelopes),
        .o_enter_release     (o_enter_release),
        .o_top_held_key      (o_top_held_key)
    );

endmodule

// ----- rtl/mnpv_checker.sv -----
module mnpv_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                o_busy,
    input  logic                                o_done,
    input  logic [mnpv_pkg::STAT_W-1:0]         o_voice_status,
    input  logic                                o_full_setup,
    input  logic                                o_pitch_update,
    input  logic                                o_restart_envelopes,
    input  logic                                o_enter_release
);

    // an accepted event always occupies the update cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted event did not raise busy");

    // the update cycle is followed by a result strobe, with busy low
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> (o_done && !o_busy))
        else $error("update cycle not followed by result");

    // full setup already covers pitch and envelope start
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_full_setup) |-> (!o_pitch_update && !o_restart_envelopes))
        else $error("full setup together with pitch or restart");

    // an envelope restart only comes with a pitch recalculation
    a_restart_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_restart_envelopes) |-> o_pitch_update)
        else $error("restart without pitch update");

    // entering release leaves the voice released
    a_rel_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_enter_release) |-> (o_voice_status == mnpv_pkg::ST_RELEASED))
        else $error("release strobe with voice not released");

endmodule

bind mono_note_priority_voice_control mnpv_checker u_mnpv_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_start             (i_start),
    .o_busy              (o_busy),
    .o_done              (o_done),
    .o_voice_status      (o_voice_status),
    .o_full_setup        (o_full_setup),
    .o_pitch_update      (o_pitch_update),
    .o_restart_envelopes (o_restart_envelopes),
    .o_enter_release     (o_enter_release)
);

// ----- bench/tb_mono_note_priority_voice_control.sv -----
module tb_mono_note_priority_voice_control;

    localparam int DEPTH        = 8;
    localparam int STALL_LIMIT  = 1000;  // cycles with no transfer at all before giving up
    localparam int RAND_PER_SET = 150;   // six random phases, about 900 events in total

    // op code 3 has no name in the package: the block must ignore it
    localparam logic [mnpv_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // one result as the block reports it
    typedef struct packed {
        logic [mnpv_pkg::STAT_W-1:0]       status;
        logic [mnpv_pkg::KEY_W-1:0]        key;
        logic [mnpv_pkg::VEL_W-1:0]        note_vel;
        logic [mnpv_pkg::VEL_W-1:0]        rel_vel;
        logic                              full_setup;
        logic                              pitch_update;
        logic                              restart_env;
        logic                              enter_release;
        logic signed [mnpv_pkg::TOP_W-1:0] top_key;
    } t_voice_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_start;
    logic                              o_busy;
    logic [mnpv_pkg::OP_W-1:0]         i_op;
    logic [mnpv_pkg::KEY_W-1:0]        i_key;
    logic [mnpv_pkg::VEL_W-1:0]        i_velocity;
    logic                              i_sustain_pedal;
    logic                              i_cfg_wr_en;
    logic [mnpv_pkg::MODE_W-1:0]       i_cfg_wr_data;
    logic                              o_done;
    logic [mnpv_pkg::STAT_W-1:0]       o_voice_status;
    logic [mnpv_pkg::KEY_W-1:0]        o_sounding_key;
    logic [mnpv_pkg::VEL_W-1:0]        o_note_velocity;
    logic [mnpv_pkg::VEL_W-1:0]        o_release_velocity;
    logic                              o_full_setup;
    logic                              o_pitch_update;
    logic                              o_restart_envelopes;
    logic                              o_enter_release;
    logic signed [mnpv_pkg::TOP_W-1:0] o_top_held_key;

    mono_note_priority_voice_control #(
        .HELD_DEPTH(DEPTH)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_op                (i_op),
        .i_key               (i_key),
        .i_velocity          (i_velocity),
        .i_sustain_pedal     (i_sustain_pedal),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .o_done              (o_done),
        .o_voice_status      (o_voice_status),
        .o_sounding_key      (o_sounding_key),
        .o_note_velocity     (o_note_velocity),
        .o_release_velocity  (o_release_velocity),
        .o_full_setup        (o_full_setup),
        .o_pitch_update      (o_pitch_update),
        .o_restart_envelopes (o_restart_envelopes),
        .o_enter_release     (o_enter_release),
        .o_top_held_key      (o_top_held_key)
    );

    // voice state as the bench expects it to be after every accepted event
    logic signed [mnpv_pkg::TOP_W-1:0] exp_held [DEPTH];  // most recent key at entry 0, empty is -1
    logic [mnpv_pkg::STAT_W-1:0]       exp_status;
    logic [mnpv_pkg::KEY_W-1:0]        exp_key;
    logic [mnpv_pkg::VEL_W-1:0]        exp_note_vel;
    logic [mnpv_pkg::VEL_W-1:0]        exp_rel_vel;
    logic [mnpv_pkg::MODE_W-1:0]       exp_mode;

    t_voice_result pending_results [$];  // results still owed by the block, oldest first
    int            n_errors    = 0;
    int            idle_pct    = 0;      // chance in percent that the sender idles a cycle
    int            idle_cycles = 0;

    // ------------------------------------------------------------------
    // clock and stall watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // any transfer on either side restarts the count
    always @(posedge i_clk) begin
        if ((i_start === 1'b1 && o_busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // voice model
    // ------------------------------------------------------------------
    function automatic void clear_voice_model();
        for (int i = 0; i < DEPTH; i++) exp_held[i] = -8'sd1;
        exp_status   = mnpv_pkg::ST_OFF;
        exp_key      = '0;
        exp_note_vel = '0;
        exp_rel_vel  = '0;
        exp_mode     = mnpv_pkg::MODE_POLY;
    endfunction

    // new key goes on top; a key already held just moves up, otherwise the oldest drops off
    function automatic void push_held_key(logic signed [mnpv_pkg::TOP_W-1:0] k);
        int i;
        for (i = 0; i < DEPTH - 1; i++)
            if (exp_held[i] == k) break;
        for (; i > 0; i--) exp_held[i] = exp_held[i-1];
        exp_held[0] = k;
    endfunction

    // remove the deepest copy of the key and close the gap; unknown keys leave the list alone
    function automatic void drop_held_key(logic signed [mnpv_pkg::TOP_W-1:0] k);
        int i;
        for (i = DEPTH - 1; i >= 0; i--)
            if (exp_held[i] == k) break;
        if (i >= 0) begin
            for (; i < DEPTH - 1; i++) exp_held[i] = exp_held[i+1];
            exp_held[DEPTH-1] = -8'sd1;
        end
    endfunction

    // applies one event to the voice model and returns what the block should report
    function automatic t_voice_result apply_note_event(logic [mnpv_pkg::OP_W-1:0] op,
                                                       logic [mnpv_pkg::KEY_W-1:0] key,
                                                       logic [mnpv_pkg::VEL_W-1:0] vel,
                                                       logic pedal);
        t_voice_result                     r;
        logic signed [mnpv_pkg::TOP_W-1:0] k;
        logic signed [mnpv_pkg::TOP_W-1:0] prev_top;
        r = '0;
        k = {1'b0, key};
        case (op)
            mnpv_pkg::OP_NOTE_ON: begin
                exp_key      = key;
                exp_note_vel = vel;
                if (exp_mode == mnpv_pkg::MODE_POLY ||
                    !(exp_status == mnpv_pkg::ST_ON ||
                      exp_status == mnpv_pkg::ST_SUSTAINED)) begin
                    r.full_setup = 1'b1;
                end else begin
                    // legato: voice keeps playing, only pitch moves
                    r.pitch_update = 1'b1;
                    if ((exp_mode == mnpv_pkg::MODE_MONO_ON ||
                         exp_mode == mnpv_pkg::MODE_MONO_BOTH) &&
                        (exp_held[0] < 0 || exp_held[0] != k))
                        r.restart_env = 1'b1;
                end
                if (exp_mode != mnpv_pkg::MODE_POLY) push_held_key(k);
                exp_status = mnpv_pkg::ST_ON;
            end
            mnpv_pkg::OP_NOTE_OFF: begin
                exp_rel_vel = vel;
                if (exp_mode != mnpv_pkg::MODE_POLY) begin
                    prev_top = exp_held[0];
                    drop_held_key(k);
                    if (exp_held[0] >= 0) begin
                        // fall back to the next most recent key if the top changed
                        if (exp_held[0] != prev_top) begin
                            exp_key        = exp_held[0][mnpv_pkg::KEY_W-1:0];
                            r.pitch_update = 1'b1;
                            if (exp_mode == mnpv_pkg::MODE_MONO_BOTH &&
                                exp_status != mnpv_pkg::ST_RELEASED)
                                r.restart_env = 1'b1;
                        end
                    end else if (pedal) begin
                        if (exp_status != mnpv_pkg::ST_RELEASED)
                            exp_status = mnpv_pkg::ST_SUSTAINED;
                    end else begin
                        r.enter_release = 1'b1;
                        exp_status      = mnpv_pkg::ST_RELEASED;
                    end
                end else if (pedal) begin
                    if (exp_status != mnpv_pkg::ST_RELEASED)
                        exp_status = mnpv_pkg::ST_SUSTAINED;
                end else begin
                    r.enter_release = 1'b1;
                    exp_status      = mnpv_pkg::ST_RELEASED;
                end
            end
            mnpv_pkg::OP_FORCE: begin
                if (exp_status == mnpv_pkg::ST_ON) exp_rel_vel = mnpv_pkg::FORCED_REL_VEL;
                r.enter_release = 1'b1;
                exp_status      = mnpv_pkg::ST_RELEASED;
            end
            default: begin
                // unused code: state unchanged, no strobes
            end
        endcase
        r.status   = exp_status;
        r.key      = exp_key;
        r.note_vel = exp_note_vel;
        r.rel_vel  = exp_rel_vel;
        r.top_key  = exp_held[0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking: every o_done cycle is one transfer
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_voice_result want;
        if (i_rst_n === 1'b1 && o_done !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual status %0d key %0d",
                         $time, o_voice_status, o_sounding_key);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("voice_status", 8'(want.status), 8'(o_voice_status));
                compare_field("sounding_key", 8'(want.key), 8'(o_sounding_key));
                compare_field("note_velocity", 8'(want.note_vel), 8'(o_note_velocity));
                compare_field("release_velocity", 8'(want.rel_vel), 8'(o_release_velocity));
                compare_field("full_setup", 8'(want.full_setup), 8'(o_full_setup));
                compare_field("pitch_update", 8'(want.pitch_update), 8'(o_pitch_update));
                compare_field("restart_envelopes", 8'(want.restart_env),
                              8'(o_restart_envelopes));
                compare_field("enter_release", 8'(want.enter_release), 8'(o_enter_release));
                compare_field("top_held_key", want.top_key, o_top_held_key);
            end
        end
    end

    // ------------------------------------------------------------------
    // event sender
    // ------------------------------------------------------------------
    // i_start stays high after a transfer so back-to-back events need no extra edge;
    // it only drops when the sender decides to idle or the bench drains
    task automatic send_event(input logic [mnpv_pkg::OP_W-1:0] op,
                              input logic [mnpv_pkg::KEY_W-1:0] key,
                              input logic [mnpv_pkg::VEL_W-1:0] vel, input logic pedal);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_op            <= op;
        i_key           <= key;
        i_velocity      <= vel;
        i_sustain_pedal <= pedal;
        // transfer happens at the first edge that sees busy low
        do @(posedge i_clk); while (o_busy !== 1'b0);
        pending_results.push_back(apply_note_event(op, key, vel, pedal));
    endtask

    // stop sending and let every owed result come back
    task automatic drain_voice();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mode only changes on an idle block
    task automatic write_mode(input logic [mnpv_pkg::MODE_W-1:0] mode);
        drain_voice();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        exp_mode = mode;
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------
    // poly mode: release on an off voice, sustain via pedal, unused op code
    task automatic test_poly_basics();
        write_mode(mnpv_pkg::MODE_POLY);
        send_event(mnpv_pkg::OP_NOTE_OFF, 7'd5,   7'd33,  1'b0);  // note off on a voice that is off
        send_event(mnpv_pkg::OP_NOTE_ON,  7'd127, 7'd127, 1'b0);
        send_event(mnpv_pkg::OP_NOTE_ON,  7'd0,   7'd0,   1'b1);  // poly retrigger: full setup
        send_event(mnpv_pkg::OP_NOTE_OFF, 7'd0,   7'd127, 1'b1);  // pedal held: sustained
        send_event(mnpv_pkg::OP_FORCE,    7'd9,   7'd1,   1'b0);  // forced release, sustained
        send_event(OP_UNUSED,             7'd85,  7'd42,  1'b1);
    endtask

    // mono retrigger: legato, same key again, fallback, unknown key, pedal
    task automatic test_mono_priority();
        write_mode(mnpv_pkg::MODE_MONO_ON);
        send_event(mnpv_pkg::OP_NOTE_ON,  7'd60, 7'd100, 1'b0);
        send_event(mnpv_pkg::OP_NOTE_ON,  7'd64, 7'd90,  1'b0);   // new key: pitch and restart
        send_event(mnpv_pkg::OP_NOTE_ON,  7'd64, 7'd80,  1'b0);   // key already on top
        send_event(mnpv_pkg::OP_NOTE_OFF, 7'd64, 7'd20,  1'b0);   // falls back to 60
        send_event(mnpv_pkg::OP_NOTE_OFF, 7'd99, 7'd21,  1'b0);   // key not held
        send_event(mnpv_pkg::OP_NOTE_OFF, 7'd60, 7'd22,  1'b1);   // list empties, pedal down
    endtask

    // overflow of the held list, fallback with retrigger, then a mode change with keys held
    task automatic test_held_overflow();
        write_mode(mnpv_pkg::MODE_MONO_BOTH);
        for (int i = 0; i < DEPTH; i++)
            send_event(mnpv_pkg::OP_NOTE_ON, 7'(100 + i), 7'(10 * i + 3), 1'b0);
        send_event(mnpv_pkg::OP_NOTE_ON,  7'd127, 7'd55, 1'b0);   // oldest key drops out
        send_event(mnpv_pkg::OP_NOTE_OFF, 7'd127, 7'd56, 1'b0);   // fallback restarts envelopes
        write_mode(mnpv_pkg::MODE_MONO_ONCE);                     // held list must survive this
        send_event(mnpv_pkg::OP_NOTE_OFF, 7'(100 + DEPTH - 1), 7'd57, 1'b0);
        send_event(mnpv_pkg::OP_FORCE,    7'd0,   7'd58, 1'b1);   // voice on: release vel 64
        // fallback on a released voice
        send_event(mnpv_pkg::OP_NOTE_OFF, 7'(100 + DEPTH - 2), 7'd59, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // random phase: mostly plausible playing from a small key set
    // ------------------------------------------------------------------
    task automatic test_random_playing(input logic [mnpv_pkg::MODE_W-1:0] mode, input int idle);
        logic [mnpv_pkg::KEY_W-1:0] key_pool [12];
        logic [mnpv_pkg::OP_W-1:0]  op;
        logic [mnpv_pkg::KEY_W-1:0] key;
        int                         pick;
        int                         n_held;
        write_mode(mode);
        idle_pct = idle;
        foreach (key_pool[i]) key_pool[i] = 7'($urandom_range(127));
        for (int n = 0; n < RAND_PER_SET; n++) begin
            pick = $urandom_range(99);
            if (pick < 48)      op = mnpv_pkg::OP_NOTE_ON;
            else if (pick < 88) op = mnpv_pkg::OP_NOTE_OFF;
            else if (pick < 96) op = mnpv_pkg::OP_FORCE;
            else                op = OP_UNUSED;
            // a quarter of keys come from anywhere so every key bit toggles
            if ($urandom_range(99) < 75) key = key_pool[$urandom_range(11)];
            else                         key = 7'($urandom_range(127));
            // note offs mostly release a key that is really held
            if (op == mnpv_pkg::OP_NOTE_OFF && $urandom_range(99) < 70) begin
                n_held = 0;
                for (int i = 0; i < DEPTH; i++) if (exp_held[i] >= 0) n_held++;
                if (n_held > 0)
                    key = exp_held[$urandom_range(n_held - 1)][mnpv_pkg::KEY_W-1:0];
            end
            send_event(op, key, 7'($urandom_range(127)), $urandom_range(99) < 25);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        i_start         <= 1'b0;
        i_op            <= mnpv_pkg::OP_NOTE_ON;
        i_key           <= '0;
        i_velocity      <= '0;
        i_sustain_pedal <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= mnpv_pkg::MODE_POLY;
        clear_voice_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_poly_basics();
        test_mono_priority();
        test_held_overflow();

        // idling phases: sender at 0%, 77%, 0%, 28%, 0% and 77%; the receiver cannot stall
        test_random_playing(mnpv_pkg::MODE_MONO_ON,   0);
        test_random_playing(mnpv_pkg::MODE_MONO_BOTH, 77);
        test_random_playing(mnpv_pkg::MODE_MONO_ONCE, 0);
        test_random_playing(mnpv_pkg::MODE_POLY,      28);
        test_random_playing(mnpv_pkg::MODE_MONO_BOTH, 0);
        test_random_playing(mnpv_pkg::MODE_MONO_ON,   77);

        // drain_voice also gives the block time to show stray results
        drain_voice();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
